FILE: rtl/derfx_pkg.sv
package derfx_pkg;

    localparam int VALUE_BYTES = 32;
    localparam int OUT_BYTES   = 32;
    localparam int MIN_BYTES   = 6;
    localparam int MEM_WORDS   = 16;
    localparam int ADDR_W      = $clog2(MEM_WORDS);
    localparam int KEEP_MAX    = (VALUE_BYTES < OUT_BYTES) ? VALUE_BYTES : OUT_BYTES;

    localparam logic [7:0] SEQ_TAG = 8'h30;
    localparam logic [7:0] INT_TAG = 8'h02;

    typedef enum logic [3:0] {
        PH_SEQ_TAG,
        PH_SEQ_LEN,
        PH_R_TAG,
        PH_R_LEN,
        PH_R_BODY,
        PH_S_TAG,
        PH_S_LEN,
        PH_S_BODY,
        PH_DONE
    } phase_t;

    // output byte position of the next body byte; negative while it falls off the left
    typedef logic signed [9:0] pos_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;   // {bank, S not R, word}
        logic [2:0]        lane;
        logic [7:0]        data;
    } wr_req_t;

    typedef struct packed {
        logic       valid;
        logic       ok;
        logic       bank;
        logic [5:0] thr_r;   // first visible output byte of R
        logic [5:0] thr_s;
    } sig_done_t;

    function automatic logic [5:0] thresh_of(input logic [7:0] len);
        logic [5:0] kept;
        kept = (len > 8'(KEEP_MAX)) ? 6'(KEEP_MAX) : len[5:0];
        return 6'(OUT_BYTES) - kept;
    endfunction

endpackage

FILE: rtl/der_signature_to_fixed_r_s.sv
// channel   dir  handshake                   payload
// byte      in   byte_valid / byte_stall     data_byte[7:0], end_of_signature
// result    out  result_valid / result_stall ok, value_word[63:0], word_index[2:0], final_word
//
// Bytes are taken one per cycle. A good signature yields eight words, one per cycle while
// result_stall is low, read from a two-bank word memory through its read register and the
// output register. The last byte of a signature stalls while the previous signature's words
// are still being read out.
// Reset is asynchronous and needs no clearing pass: unwritten bytes are masked by length.
module der_signature_to_fixed_r_s
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_signature,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        ok,
    output logic [63:0] value_word,
    output logic [2:0]  word_index,
    output logic        final_word
);

    derfx_pkg::wr_req_t   wr_req;
    derfx_pkg::sig_done_t done;

    logic       byte_accept;
    logic       job_busy_reg;
    logic [2:0] job_cnt_reg;
    logic       job_bank_reg;
    logic       job_ok_reg;
    logic [5:0] job_thr_r_reg;
    logic [5:0] job_thr_s_reg;
    logic       job_last;
    logic       issue;

    logic        s1_valid_reg;
    logic        s1_ok_reg;
    logic [2:0]  s1_idx_reg;
    logic        s1_final_reg;
    logic [5:0]  s1_thr_reg;
    logic        s1_load;
    logic        s1_adv;
    logic        s2_free;
    logic [63:0] rd_data;
    logic [7:0]  byte_keep;
    logic [63:0] masked_word;

    logic        result_valid_reg;
    logic        ok_reg;
    logic [63:0] value_word_reg;
    logic [2:0]  word_index_reg;
    logic        final_word_reg;

    assign byte_stall  = job_busy_reg & end_of_signature;
    assign byte_accept = byte_valid & ~byte_stall;

    derfx_parse u_parse
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (byte_accept),
        .data_byte        (data_byte),
        .end_of_signature (end_of_signature),
        .wr               (wr_req),
        .done             (done)
    );

    assign s2_free  = ~result_valid_reg | ~result_stall;
    assign s1_adv   = s1_valid_reg & s2_free;
    assign s1_load  = ~s1_valid_reg | s2_free;
    assign issue    = job_busy_reg & s1_load;
    assign job_last = ~job_ok_reg | (job_cnt_reg == 3'd7);

    derfx_store u_store
    (
        .clk     (clk),
        .wr      (wr_req),
        .rd_en   (issue & job_ok_reg),
        .rd_addr ({job_bank_reg, job_cnt_reg}),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_busy_reg  <= 1'b0;
            job_cnt_reg   <= 3'd0;
            job_bank_reg  <= 1'b0;
            job_ok_reg    <= 1'b0;
            job_thr_r_reg <= 6'd0;
            job_thr_s_reg <= 6'd0;
        end
        else if (done.valid)
        begin
            job_busy_reg  <= 1'b1;
            job_cnt_reg   <= 3'd0;
            job_bank_reg  <= done.bank;
            job_ok_reg    <= done.ok;
            job_thr_r_reg <= done.thr_r;
            job_thr_s_reg <= done.thr_s;
        end
        else if (issue)
        begin
            job_cnt_reg <= job_cnt_reg + 3'd1;
            if (job_last)
            begin
                job_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_ok_reg    <= job_ok_reg;
            s1_idx_reg   <= job_ok_reg ? job_cnt_reg : 3'd0;
            s1_final_reg <= job_last;
            s1_thr_reg   <= job_cnt_reg[2] ? job_thr_s_reg : job_thr_r_reg;
        end
    end

    // bytes left of the integer's first kept byte read as zero
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            byte_keep[j] = s1_ok_reg && ({1'b0, s1_idx_reg[1:0], 3'(j)} >= s1_thr_reg);
            masked_word[8*(7-j) +: 8] = byte_keep[j] ? rd_data[8*(7-j) +: 8] : 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            ok_reg         <= s1_ok_reg;
            value_word_reg <= masked_word;
            word_index_reg <= s1_idx_reg;
            final_word_reg <= s1_final_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign ok           = ok_reg;
    assign value_word   = value_word_reg;
    assign word_index   = word_index_reg;
    assign final_word   = final_word_reg;

    a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
        wr_req.en && issue && job_ok_reg |-> wr_req.addr[derfx_pkg::ADDR_W-1] != job_bank_reg)
        else $error("parser writes the bank being read out");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !ok |-> value_word == 64'd0 && word_index == 3'd0 && final_word)
        else $error("failure result not a single zero word");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ok |-> final_word == (word_index == 3'd7))
        else $error("final mark not on the last S word");

endmodule

FILE: rtl/derfx_store.sv
module derfx_store
(
    input  logic                            clk,
    input  derfx_pkg::wr_req_t              wr,
    input  logic                            rd_en,
    input  logic [derfx_pkg::ADDR_W-1:0]    rd_addr,
    output logic [63:0]                     rd_data
);

    logic [63:0] mem [derfx_pkg::MEM_WORDS];
    logic [63:0] rd_data_reg;

    // lane 0 is the most significant byte of the word
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr][{~wr.lane, 3'b000} +: 8] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/derfx_parse.sv
module derfx_parse
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              data_byte,
    input  logic                    end_of_signature,
    output derfx_pkg::wr_req_t      wr,
    output derfx_pkg::sig_done_t    done
);

    localparam derfx_pkg::pos_t POS_MIN = derfx_pkg::pos_t'(derfx_pkg::OUT_BYTES
                                                            - derfx_pkg::VALUE_BYTES);
    localparam derfx_pkg::pos_t POS_END = derfx_pkg::pos_t'(derfx_pkg::OUT_BYTES);

    derfx_pkg::phase_t phase_reg, phase_next;
    logic [7:0]        rem_reg, rem_next;
    logic [2:0]        seen_reg, seen_next;
    logic              failed_reg, failed_next;
    derfx_pkg::pos_t   pos_reg, pos_next;
    logic [5:0]        thr_r_reg, thr_r_next;
    logic [5:0]        thr_s_reg, thr_s_next;
    logic              bank_reg;
    logic              in_body;

    always_comb
    begin
        phase_next  = phase_reg;
        rem_next    = rem_reg;
        failed_next = failed_reg;
        pos_next    = pos_reg;
        thr_r_next  = thr_r_reg;
        thr_s_next  = thr_s_reg;
        seen_next   = (seen_reg < 3'(derfx_pkg::MIN_BYTES)) ? seen_reg + 3'd1 : seen_reg;
        if (!failed_reg)
        begin
            unique case (phase_reg)
                derfx_pkg::PH_SEQ_TAG:
                begin
                    if (data_byte != derfx_pkg::SEQ_TAG) failed_next = 1'b1;
                    else phase_next = derfx_pkg::PH_SEQ_LEN;
                end
                derfx_pkg::PH_SEQ_LEN:
                begin
                    phase_next = derfx_pkg::PH_R_TAG;
                end
                derfx_pkg::PH_R_TAG:
                begin
                    if (data_byte != derfx_pkg::INT_TAG) failed_next = 1'b1;
                    else phase_next = derfx_pkg::PH_R_LEN;
                end
                derfx_pkg::PH_R_LEN:
                begin
                    rem_next   = data_byte;
                    pos_next   = POS_END - derfx_pkg::pos_t'({2'b00, data_byte});
                    thr_r_next = derfx_pkg::thresh_of(data_byte);
                    phase_next = (data_byte != 8'd0) ? derfx_pkg::PH_R_BODY
                                                     : derfx_pkg::PH_S_TAG;
                end
                derfx_pkg::PH_R_BODY:
                begin
                    pos_next = pos_reg + derfx_pkg::pos_t'(1);
                    rem_next = rem_reg - 8'd1;
                    if (rem_reg == 8'd1) phase_next = derfx_pkg::PH_S_TAG;
                end
                derfx_pkg::PH_S_TAG:
                begin
                    if (data_byte != derfx_pkg::INT_TAG) failed_next = 1'b1;
                    else phase_next = derfx_pkg::PH_S_LEN;
                end
                derfx_pkg::PH_S_LEN:
                begin
                    rem_next   = data_byte;
                    pos_next   = POS_END - derfx_pkg::pos_t'({2'b00, data_byte});
                    thr_s_next = derfx_pkg::thresh_of(data_byte);
                    phase_next = (data_byte != 8'd0) ? derfx_pkg::PH_S_BODY
                                                     : derfx_pkg::PH_DONE;
                end
                derfx_pkg::PH_S_BODY:
                begin
                    pos_next = pos_reg + derfx_pkg::pos_t'(1);
                    rem_next = rem_reg - 8'd1;
                    if (rem_reg == 8'd1) phase_next = derfx_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = derfx_pkg::PH_DONE;
                end
            endcase
        end
    end

    // a body byte lands in memory only if it is both kept and visible
    always_comb
    begin
        in_body = (phase_reg == derfx_pkg::PH_R_BODY) || (phase_reg == derfx_pkg::PH_S_BODY);
        wr.en   = accept && !failed_reg && in_body
                  && (pos_reg >= derfx_pkg::pos_t'(0)) && (pos_reg >= POS_MIN)
                  && (pos_reg < POS_END);
        wr.addr = {bank_reg, phase_reg == derfx_pkg::PH_S_BODY, pos_reg[4:3]};
        wr.lane = pos_reg[2:0];
        wr.data = data_byte;

        done.valid = accept && end_of_signature;
        done.ok    = !failed_next && (phase_next == derfx_pkg::PH_DONE)
                     && (seen_next >= 3'(derfx_pkg::MIN_BYTES));
        done.bank  = bank_reg;
        done.thr_r = thr_r_next;
        done.thr_s = thr_s_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= derfx_pkg::PH_SEQ_TAG;
            rem_reg    <= 8'd0;
            seen_reg   <= 3'd0;
            failed_reg <= 1'b0;
            pos_reg    <= derfx_pkg::pos_t'(0);
            thr_r_reg  <= 6'(derfx_pkg::OUT_BYTES);
            thr_s_reg  <= 6'(derfx_pkg::OUT_BYTES);
            bank_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (end_of_signature)
            begin
                phase_reg  <= derfx_pkg::PH_SEQ_TAG;
                rem_reg    <= 8'd0;
                seen_reg   <= 3'd0;
                failed_reg <= 1'b0;
                pos_reg    <= derfx_pkg::pos_t'(0);
                thr_r_reg  <= 6'(derfx_pkg::OUT_BYTES);
                thr_s_reg  <= 6'(derfx_pkg::OUT_BYTES);
                bank_reg   <= ~bank_reg;
            end
            else
            begin
                phase_reg  <= phase_next;
                rem_reg    <= rem_next;
                seen_reg   <= seen_next;
                failed_reg <= failed_next;
                pos_reg    <= pos_next;
                thr_r_reg  <= thr_r_next;
                thr_s_reg  <= thr_s_next;
            end
        end
    end

endmodule
